FILE: sv/bmwh_pkg.sv
// shared types and constants for the bootloader write-memory host
// no dependencies; used by every module of the block

package bmwh_pkg;

  localparam int SIZE_BITS   = 24;
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 9;
  localparam int BEAT_W      = 3;
  localparam int MAX_CHUNK_D = 256;
  localparam int QUEUE_DEPTH_D = 4;

  // input command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_REPLY = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  // protocol bytes
  localparam logic [7:0] ACK_BYTE  = 8'h79;
  localparam logic [7:0] CMD_BYTE0 = 8'h31;
  localparam logic [7:0] CMD_BYTE1 = 8'hCE;

  // status codes
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_SIZE_ERR  = 3'd2;
  localparam logic [2:0] ST_CMD_NACK  = 3'd3;
  localparam logic [2:0] ST_ADDR_NACK = 3'd4;
  localparam logic [2:0] ST_DATA_NACK = 3'd5;

  // work handed from front to back
  typedef enum logic [2:0] {
    JOB_CMD      = 3'd0,
    JOB_ADDR     = 3'd1,
    JOB_LEN      = 3'd2,
    JOB_DATA     = 3'd3,
    JOB_DATA_END = 3'd4,
    JOB_FIN      = 3'd5
  } job_kind_t;

  typedef struct packed {
    job_kind_t              kind;
    logic [ADDR_W-1:0]      word;    // address, length byte, or data byte / checksum bytes
    logic [SIZE_BITS-1:0]   offset;
    logic [COUNT_W-1:0]     count;
    logic [2:0]             status;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: sv/bmwh_front.sv
// front end: takes input items, runs the sequence state and posts jobs
// depends on bmwh_pkg

module bmwh_front import bmwh_pkg::*; #(
  parameter int MAX_CHUNK = MAX_CHUNK_D
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           cmd,
  input  logic [7:0]           value,
  input  logic [ADDR_W-1:0]    start_address,
  input  logic [SIZE_BITS-1:0] firmware_size,
  output logic                 push,
  output job_t                 job
);

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_CMD_ACK  = 5'b00010,
    PH_ADDR_ACK = 5'b00100,
    PH_DATA     = 5'b01000,
    PH_DATA_ACK = 5'b10000
  } phase_t;

  localparam logic [SIZE_BITS-1:0] MAX_CHUNK_W = SIZE_BITS'(MAX_CHUNK);

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] bytes_written, bytes_written_next;
  logic [COUNT_W-1:0]   chunk_length, chunk_length_next;
  logic [COUNT_W-1:0]   chunk_bytes_seen, chunk_bytes_seen_next;
  logic [7:0]           running_xor, running_xor_next;

  logic                 ack;
  logic [SIZE_BITS-1:0] remaining;
  logic [COUNT_W-1:0]   len;
  logic [COUNT_W-1:0]   len_m1;
  logic [SIZE_BITS-1:0] bw_sum;
  logic [COUNT_W-1:0]   seen_inc;
  logic [7:0]           xor_upd;

  assign ack       = (value == ACK_BYTE);
  assign remaining = firmware_size - bytes_written;
  assign len       = (remaining > MAX_CHUNK_W) ? COUNT_W'(MAX_CHUNK)
                                               : remaining[COUNT_W-1:0];
  assign len_m1    = len - COUNT_W'(1);
  assign bw_sum    = bytes_written + SIZE_BITS'(chunk_length);
  assign seen_inc  = chunk_bytes_seen + COUNT_W'(1);
  assign xor_upd   = running_xor ^ value;

  always_comb begin
    phase_next            = phase;
    bytes_written_next    = bytes_written;
    chunk_length_next     = chunk_length;
    chunk_bytes_seen_next = chunk_bytes_seen;
    running_xor_next      = running_xor;
    push                  = 1'b0;
    job                   = '0;
    job.kind              = JOB_FIN;
    case (cmd)
      CMD_START: begin
        bytes_written_next    = '0;
        chunk_length_next     = '0;
        chunk_bytes_seen_next = '0;
        running_xor_next      = '0;
        push                  = 1'b1;
        if (firmware_size == '0 || firmware_size[1:0] != 2'b00) begin
          job.status = ST_SIZE_ERR;
          phase_next = PH_IDLE;
        end else begin
          job.kind   = JOB_CMD;
          phase_next = PH_CMD_ACK;
        end
      end
      CMD_REPLY: begin
        case (phase)
          PH_CMD_ACK: begin
            push = 1'b1;
            if (ack) begin
              job.kind          = JOB_ADDR;
              job.word          = start_address + ADDR_W'(bytes_written);
              chunk_length_next = '0;
              phase_next        = PH_ADDR_ACK;
            end else begin
              job.status = ST_CMD_NACK;
              phase_next = PH_IDLE;
            end
          end
          PH_ADDR_ACK: begin
            push = 1'b1;
            if (!ack) begin
              job.status = ST_ADDR_NACK;
              phase_next = PH_IDLE;
            end else if (firmware_size <= bytes_written) begin
              job.status = ST_COMPLETE;
              phase_next = PH_IDLE;
            end else begin
              job.kind              = JOB_LEN;
              job.word              = ADDR_W'(len_m1[7:0]);
              job.offset            = bytes_written;
              job.count             = len;
              chunk_length_next     = len;
              chunk_bytes_seen_next = '0;
              running_xor_next      = len_m1[7:0];
              phase_next            = PH_DATA;
            end
          end
          PH_DATA_ACK: begin
            push = 1'b1;
            if (ack) begin
              bytes_written_next = bw_sum;
              if (firmware_size <= bw_sum) begin
                job.status = ST_COMPLETE;
                phase_next = PH_IDLE;
              end else begin
                job.kind   = JOB_CMD;
                phase_next = PH_CMD_ACK;
              end
            end else begin
              job.status = ST_DATA_NACK;
              phase_next = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      CMD_DATA: begin
        if (phase == PH_DATA) begin
          push                  = 1'b1;
          running_xor_next      = xor_upd;
          chunk_bytes_seen_next = seen_inc;
          if (seen_inc >= chunk_length) begin
            job.kind   = JOB_DATA_END;
            job.word   = ADDR_W'({xor_upd, value});
            phase_next = PH_DATA_ACK;
          end else begin
            job.kind = JOB_DATA;
            job.word = ADDR_W'(value);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bytes_written    <= '0;
      chunk_length     <= '0;
      chunk_bytes_seen <= '0;
      running_xor      <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      bytes_written    <= bytes_written_next;
      chunk_length     <= chunk_length_next;
      chunk_bytes_seen <= chunk_bytes_seen_next;
      running_xor      <= running_xor_next;
    end
  end

`ifndef NO_ASSERTIONS
  // while taking data the chunk is never already complete
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (chunk_bytes_seen < chunk_length))
    else $error("data phase with chunk already complete");
`endif

endmodule

FILE: sv/bmwh_queue.sv
// short job queue between front and back
// depends on bmwh_pkg

module bmwh_queue import bmwh_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_D
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !push)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> !pop)
    else $error("job queue underflow");
`endif

endmodule

FILE: sv/bmwh_back.sv
// back end: expands queued jobs into result beats behind an output register
// depends on bmwh_pkg

module bmwh_back import bmwh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_t        head,
  input  q_status_t   stat,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic        m_tlast
);

  function automatic logic [BEAT_W-1:0] beat_total(input job_kind_t kind);
    case (kind)
      JOB_CMD:      beat_total = BEAT_W'(2);
      JOB_ADDR:     beat_total = BEAT_W'(5);
      JOB_DATA_END: beat_total = BEAT_W'(2);
      default:      beat_total = BEAT_W'(1);
    endcase
  endfunction

  logic [BEAT_W-1:0]    idx;
  logic                 load;
  logic                 beat_last;
  logic                 tx_valid, need_data;
  logic [7:0]           tx_byte;
  logic [SIZE_BITS-1:0] data_offset;
  logic [COUNT_W-1:0]   data_count;
  logic [2:0]           status;
  logic [7:0]           addr_xor;

  assign load      = !stat.empty && (!m_tvalid || m_tready);
  assign beat_last = (idx == beat_total(head.kind) - BEAT_W'(1));
  assign pop       = load && beat_last;
  assign addr_xor  = head.word[31:24] ^ head.word[23:16] ^ head.word[15:8] ^ head.word[7:0];

  always_comb begin
    tx_valid    = 1'b1;
    tx_byte     = head.word[7:0];
    need_data   = 1'b0;
    data_offset = '0;
    data_count  = '0;
    status      = ST_BUSY;
    case (head.kind)
      JOB_CMD: begin
        tx_byte = (idx == '0) ? CMD_BYTE0 : CMD_BYTE1;
      end
      JOB_ADDR: begin
        // big-endian address then its checksum
        case (idx)
          BEAT_W'(0): tx_byte = head.word[31:24];
          BEAT_W'(1): tx_byte = head.word[23:16];
          BEAT_W'(2): tx_byte = head.word[15:8];
          BEAT_W'(3): tx_byte = head.word[7:0];
          default:    tx_byte = addr_xor;
        endcase
      end
      JOB_LEN: begin
        need_data   = 1'b1;
        data_offset = head.offset;
        data_count  = head.count;
      end
      JOB_DATA: ;
      JOB_DATA_END: begin
        tx_byte = (idx == '0) ? head.word[7:0] : head.word[15:8];
      end
      default: begin
        tx_valid = 1'b0;
        tx_byte  = '0;
        status   = head.status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= beat_last ? '0 : idx + BEAT_W'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {2'b00, status, data_count, data_offset, need_data, tx_byte, tx_valid};
      m_tlast <= beat_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !stat.empty |-> (idx < beat_total(head.kind)))
    else $error("beat index beyond job length");
`endif

endmodule

FILE: sv/bootloader_memory_write_host_core.sv
// Host side of a serial bootloader write-memory sequence. An input item is
// taken in every cycle while the job queue (QUEUE_DEPTH entries) has room;
// the front end updates the sequence state in that same cycle. Each item
// gives zero to five result beats; they pass through the queue and are sent
// one per cycle, while m_tready is high, from the back end's output
// register, so a sustained rate of one item per cycle holds as long as
// results average one beat per item; the address reply (five beats) and the
// last data byte (two beats) are absorbed by the queue. Configuration is
// over an APB-style port: start_address at 0x0, firmware_size at 0x4.
// depends on bmwh_pkg, bmwh_front, bmwh_queue, bmwh_back

module bootloader_memory_write_host_core import bmwh_pkg::*; #(
  parameter int MAX_CHUNK   = MAX_CHUNK_D,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // value[7:0]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // tx_valid[0], tx_byte[8:1], need_data[9],
                                 // data_offset[33:10], data_count[42:34],
                                 // status[45:43], zero[47:46]
  output logic        m_tlast    // last beat of an item
);

  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic REG_FIRMWARE_SIZE = 1'b1;

  logic [ADDR_W-1:0]    start_address;
  logic [SIZE_BITS-1:0] firmware_size;
  logic                 accept;
  logic                 push;
  logic                 pop;
  job_t                 push_job;
  job_t                 head;
  q_status_t            stat;

  assign pready   = 1'b1;
  assign s_tready = !stat.full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
      firmware_size <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_START_ADDRESS: start_address <= pwdata;
        REG_FIRMWARE_SIZE: firmware_size <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_START_ADDRESS: prdata = start_address;
      REG_FIRMWARE_SIZE: prdata = 32'(firmware_size);
      default:           prdata = '0;
    endcase
  end

  bmwh_front #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (s_tuser),
    .value         (s_tdata),
    .start_address (start_address),
    .firmware_size (firmware_size),
    .push          (push),
    .job           (push_job)
  );

  bmwh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push && accept),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  bmwh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: test/bmwh_checker.sv
// result checker for the bootloader write-memory host: tracks register writes
// and accepted input beats, predicts the result beats and compares them
// depends on bmwh_pkg
`timescale 1ns / 100ps

module bmwh_checker import bmwh_pkg::*; #(
  parameter logic [2:0] REG_START_ADDR = 3'h0,
  parameter logic [2:0] REG_FW_SIZE    = 3'h4,
  parameter int         MAX_CHUNK      = MAX_CHUNK_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // value[7:0]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // tx_valid[0], tx_byte[8:1], need_data[9],
                                 // data_offset[33:10], data_count[42:34],
                                 // status[45:43]
  input  logic        m_tlast,
  output int          mismatches,
  output int          beats_owed,
  output int          beats_checked,
  output int          completions,
  output int          aborts
);

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CMD_ACK,
    SEQ_ADDR_ACK,
    SEQ_DATA,
    SEQ_DATA_ACK
  } seq_state_t;

  typedef struct packed {
    logic                 tx_valid;
    logic [7:0]           tx_byte;
    logic                 need_data;
    logic [SIZE_BITS-1:0] data_offset;
    logic [COUNT_W-1:0]   data_count;
    logic [2:0]           status;
    logic                 last;
  } host_beat_t;

  host_beat_t expected_beats [$];

  logic [ADDR_W-1:0]    flash_base;
  logic [SIZE_BITS-1:0] image_size;
  seq_state_t           seq_state;
  logic [SIZE_BITS-1:0] bytes_done;
  logic [COUNT_W-1:0]   chunk_len;
  logic [COUNT_W-1:0]   chunk_taken;
  logic [7:0]           chunk_xor;

  int miss_total;
  int checked_total;
  int done_total;
  int abort_total;

  function automatic host_beat_t sent(logic [7:0] b);
    host_beat_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    return r;
  endfunction

  function automatic host_beat_t closing(logic [2:0] st);
    host_beat_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic int field_miss(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic host_step(input logic [1:0] cmd, input logic [7:0] val);
    host_beat_t           burst [5];
    int                   n;
    int                   i;
    logic                 ack;
    logic [ADDR_W-1:0]    addr;
    logic [SIZE_BITS-1:0] left;
    logic [COUNT_W-1:0]   len;
    n = 0;
    ack = (val == ACK_BYTE);
    case (cmd)
      CMD_START: begin
        bytes_done  = '0;
        chunk_len   = '0;
        chunk_taken = '0;
        chunk_xor   = '0;
        if (image_size == '0 || image_size[1:0] != 2'b00) begin
          burst[0] = closing(ST_SIZE_ERR);
          n = 1;
          seq_state = SEQ_IDLE;
        end else begin
          burst[0] = sent(CMD_BYTE0);
          burst[1] = sent(CMD_BYTE1);
          n = 2;
          seq_state = SEQ_CMD_ACK;
        end
      end
      CMD_REPLY: begin
        case (seq_state)
          SEQ_CMD_ACK: begin
            if (ack) begin
              // big-endian address, wraps at 32 bits
              addr = flash_base + ADDR_W'(bytes_done);
              burst[0] = sent(addr[31:24]);
              burst[1] = sent(addr[23:16]);
              burst[2] = sent(addr[15:8]);
              burst[3] = sent(addr[7:0]);
              burst[4] = sent(addr[31:24] ^ addr[23:16] ^ addr[15:8] ^ addr[7:0]);
              n = 5;
              chunk_len = '0;
              seq_state = SEQ_ADDR_ACK;
            end else begin
              burst[0] = closing(ST_CMD_NACK);
              n = 1;
              seq_state = SEQ_IDLE;
            end
          end
          SEQ_ADDR_ACK: begin
            if (!ack) begin
              burst[0] = closing(ST_ADDR_NACK);
              n = 1;
              seq_state = SEQ_IDLE;
            end else if (image_size <= bytes_done) begin
              // size shrunk under a running transfer
              burst[0] = closing(ST_COMPLETE);
              n = 1;
              seq_state = SEQ_IDLE;
            end else begin
              left = image_size - bytes_done;
              len = (left > SIZE_BITS'(MAX_CHUNK)) ? COUNT_W'(MAX_CHUNK)
                                                    : left[COUNT_W-1:0];
              chunk_len   = len;
              chunk_taken = '0;
              chunk_xor   = 8'(len - 9'd1);
              burst[0] = sent(chunk_xor);
              burst[0].need_data   = 1'b1;
              burst[0].data_offset = bytes_done;
              burst[0].data_count  = len;
              n = 1;
              seq_state = SEQ_DATA;
            end
          end
          SEQ_DATA_ACK: begin
            if (ack) begin
              bytes_done = bytes_done + SIZE_BITS'(chunk_len);
              if (image_size <= bytes_done) begin
                burst[0] = closing(ST_COMPLETE);
                n = 1;
                seq_state = SEQ_IDLE;
              end else begin
                burst[0] = sent(CMD_BYTE0);
                burst[1] = sent(CMD_BYTE1);
                n = 2;
                seq_state = SEQ_CMD_ACK;
              end
            end else begin
              burst[0] = closing(ST_DATA_NACK);
              n = 1;
              seq_state = SEQ_IDLE;
            end
          end
          default: ;
        endcase
      end
      CMD_DATA: begin
        if (seq_state == SEQ_DATA) begin
          chunk_xor   = chunk_xor ^ val;
          chunk_taken = chunk_taken + 9'd1;
          burst[0] = sent(val);
          n = 1;
          if (chunk_taken >= chunk_len) begin
            burst[1] = sent(chunk_xor);
            n = 2;
            seq_state = SEQ_DATA_ACK;
          end
        end
      end
      default: ;
    endcase
    if (n > 0) burst[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_beats.push_back(burst[i]);
  endtask

  always @(posedge clk) begin : watch
    host_beat_t want;
    if (rst) begin
      flash_base  = '0;
      image_size  = '0;
      seq_state   = SEQ_IDLE;
      bytes_done  = '0;
      chunk_len   = '0;
      chunk_taken = '0;
      chunk_xor   = '0;
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_START_ADDR) flash_base = pwdata;
        else if (paddr == REG_FW_SIZE) image_size = pwdata[SIZE_BITS-1:0];
      end
      if (s_tvalid && s_tready) host_step(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        checked_total++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: tdata 0x%0h", m_tdata);
          miss_total++;
        end else begin
          want = expected_beats.pop_front();
          miss_total += field_miss("tx_valid", want.tx_valid, m_tdata[0]);
          miss_total += field_miss("tx_byte", want.tx_byte, m_tdata[8:1]);
          miss_total += field_miss("need_data", want.need_data, m_tdata[9]);
          miss_total += field_miss("data_offset", want.data_offset, m_tdata[33:10]);
          miss_total += field_miss("data_count", want.data_count, m_tdata[42:34]);
          miss_total += field_miss("status", want.status, m_tdata[45:43]);
          miss_total += field_miss("last", want.last, m_tlast);
          if (want.status == ST_COMPLETE) done_total++;
          else if (want.status != ST_BUSY) abort_total++;
        end
      end
    end
    mismatches    <= miss_total;
    beats_owed    <= expected_beats.size();
    beats_checked <= checked_total;
    completions   <= done_total;
    aborts        <= abort_total;
  end

endmodule

FILE: test/bootloader_memory_write_host_core_test.sv
// top of the bootloader write-memory host testbench: clock, reset, register
// writes, input and result stream drivers, and the verdict
// depends on bmwh_pkg, bmwh_checker and the block under test
`timescale 1ns / 100ps

module bootloader_memory_write_host_core_test;
  import bmwh_pkg::*;

  localparam logic [2:0] REG_START_ADDR = 3'h0;
  localparam logic [2:0] REG_FW_SIZE    = 3'h4;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int RANDOM_ITEMS = 140;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int PRESSURE_ITEMS = 16;
  localparam int PARTIAL_ITEMS = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // value[7:0]
  logic [1:0]  s_tuser = '0;    // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // tx_valid[0], tx_byte[8:1], need_data[9],
                                // data_offset[33:10], data_count[42:34],
                                // status[45:43]
  logic        m_tlast;

  int mismatches;
  int beats_owed;
  int beats_checked;
  int completions;
  int aborts;

  bit                   calm = 1'b0;
  int                   holds_asked = 0;
  int                   holds_served = 0;
  int                   items_sent = 0;
  int                   random_items = 0;
  int                   settings_used = 0;
  logic [SIZE_BITS-1:0] cur_size = '0;

  bootloader_memory_write_host_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  bmwh_checker #(
    .REG_START_ADDR (REG_START_ADDR),
    .REG_FW_SIZE    (REG_FW_SIZE)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .beats_owed    (beats_owed),
    .beats_checked (beats_checked),
    .completions   (completions),
    .aborts        (aborts)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAIL bootloader_memory_write_host_core");
    $finish;
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin : sink
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
    @(posedge clk);
  endtask

  // one input beat, with random gaps ahead of it
  task automatic offer(input logic [1:0] cmd, input logic [7:0] val);
    while (!calm && $urandom_range(0, 99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // wait for every expected beat, then let any silent work run out
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic noise_maybe();
    if ($urandom_range(0, 99) < 6) offer(2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  task automatic answer(output bit acked);
    logic [7:0] reply;
    noise_maybe();
    if ($urandom_range(0, 99) < 5) begin
      reply = 8'($urandom);
      if (reply == ACK_BYTE) reply = 8'h00;
      acked = 1'b0;
    end else begin
      reply = ACK_BYTE;
      acked = 1'b1;
    end
    offer(CMD_REPLY, reply);
    random_items++;
  endtask

  // a well-formed write of the whole image, broken only by noise or a nack
  task automatic transfer();
    int off;
    int chunk;
    int i;
    bit ok;
    noise_maybe();
    offer(CMD_START, 8'($urandom));
    random_items++;
    if (cur_size == '0 || cur_size[1:0] != 2'b00) return;
    for (off = 0; off < int'(cur_size); off += chunk) begin
      chunk = (int'(cur_size) - off > MAX_CHUNK_D) ? MAX_CHUNK_D : int'(cur_size) - off;
      answer(ok);
      if (!ok) return;
      answer(ok);
      if (!ok) return;
      for (i = 0; i < chunk; i++) begin
        noise_maybe();
        offer(CMD_DATA, 8'($urandom));
        random_items++;
      end
      answer(ok);
      if (!ok) return;
    end
  endtask

  initial begin : stimulus
    int phase_no;
    int i;
    logic [31:0] base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // size checks
    apb_write(REG_FW_SIZE, 32'd0);
    offer(CMD_START, 8'h00);
    quiesce();
    apb_write(REG_FW_SIZE, 32'd6);
    offer(CMD_START, 8'hFF);
    quiesce();
    apb_write(REG_FW_SIZE, 32'h00FF_FFFF);
    offer(CMD_START, 8'h55);
    quiesce();
    apb_write(REG_START_ADDR, 32'hFFFF_FFFF);
    apb_write(REG_FW_SIZE, 32'd4);
    cur_size = 24'd4;

    // stray beats while idle, restart while busy, then each kind of nack
    offer(CMD_REPLY, ACK_BYTE);
    offer(CMD_DATA, 8'hFF);
    offer(CMD_UNUSED, 8'hFF);
    offer(CMD_START, 8'h00);
    offer(CMD_START, 8'hAA);
    offer(CMD_DATA, 8'h00);
    offer(CMD_REPLY, 8'h00);
    offer(CMD_START, 8'h00);
    offer(CMD_REPLY, ACK_BYTE);
    offer(CMD_REPLY, 8'h7A);
    offer(CMD_START, 8'h00);
    offer(CMD_REPLY, ACK_BYTE);
    offer(CMD_REPLY, ACK_BYTE);
    offer(CMD_REPLY, ACK_BYTE);   // ignored while data is being taken
    offer(CMD_DATA, 8'h00);
    offer(CMD_DATA, 8'hFF);
    offer(CMD_DATA, 8'hA5);
    offer(CMD_DATA, 8'h5A);
    offer(CMD_REPLY, 8'hFF);

    // random transfers over a spread of settings
    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiesce();
      calm = (phase_no >= 1 && phase_no < 3);
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 3))
          0:       base = 32'h0000_0000;
          1:       base = 32'hFFFF_FFFF;
          default: base = $urandom;
        endcase
        apb_write(REG_START_ADDR, base);
      end
      case ($urandom_range(0, 9))
        8:       cur_size = 24'($urandom_range(1, 31));
        9:       cur_size = '0;
        default: cur_size = 24'(4 * $urandom_range(1, 8));
      endcase
      apb_write(REG_FW_SIZE, 32'(cur_size));
      repeat ($urandom_range(1, 3)) transfer();
      phase_no++;
    end

    // first chunk near the top of the address space, receiver held off
    // meanwhile so the input stalls
    quiesce();
    calm = 1'b0;
    apb_write(REG_START_ADDR, 32'hFFFF_FFF8);
    apb_write(REG_FW_SIZE, 32'd16);
    cur_size = 24'd16;
    offer(CMD_START, 8'h00);
    offer(CMD_REPLY, ACK_BYTE);
    offer(CMD_REPLY, ACK_BYTE);
    calm = 1'b1;
    holds_asked++;
    for (i = 0; i < PRESSURE_ITEMS; i++) offer(CMD_DATA, 8'($urandom));
    quiesce();

    // image grows before the data ack: next address wraps past zero and a
    // full-size chunk is asked for, then a restart part way through it
    apb_write(REG_FW_SIZE, 32'h00FF_FFFC);
    cur_size = 24'hFF_FFFC;
    offer(CMD_REPLY, ACK_BYTE);
    offer(CMD_REPLY, ACK_BYTE);
    offer(CMD_REPLY, ACK_BYTE);
    for (i = 0; i < PARTIAL_ITEMS; i++) offer(CMD_DATA, 8'($urandom));
    offer(CMD_START, 8'h00);
    offer(CMD_REPLY, ACK_BYTE);
    quiesce();

    // nothing left to write by the time the address ack arrives
    calm = 1'b0;
    apb_write(REG_FW_SIZE, 32'd0);
    cur_size = '0;
    offer(CMD_REPLY, ACK_BYTE);
    offer(CMD_REPLY, ACK_BYTE);

    quiesce();
    $display("run covered %0d input beats over %0d register writes, %0d result beats checked",
             items_sent, settings_used, beats_checked);
    $display("sequences ended: %0d complete, %0d with an error status",
             completions, aborts);
    if (mismatches == 0) begin
      $display("PASS bootloader_memory_write_host_core");
    end else begin
      $display("FAIL bootloader_memory_write_host_core");
    end
    $finish;
  end

endmodule
